### rtl/heap_sort_points_by_angle_defines.svh
`ifndef HEAP_SORT_POINTS_BY_ANGLE_DEFINES_SVH
`define HEAP_SORT_POINTS_BY_ANGLE_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define HSPA_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define HSPA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### rtl/hspa_pkg.sv
`timescale 1ns / 1ps

package hspa_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int ANGLE_BITS_DEF = 24;

  localparam int ANGLE_W = 24;
  localparam int COORD_W = 32;
  localparam int DATA_W  = ANGLE_W + 2 * COORD_W;

  typedef struct packed {
    logic take_left;
    logic take_right;
  } pick_t;

endpackage

### rtl/hspa_ram.sv
`timescale 1ns / 1ps

module hspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/hspa_pick.sv
`timescale 1ns / 1ps

module hspa_pick
  import hspa_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic [ANGLE_BITS-1:0] cur_angle,
  input  logic [ANGLE_BITS-1:0] left_angle,
  input  logic [ANGLE_BITS-1:0] right_angle,
  input  logic                  has_right,
  output pick_t                 pick
);

  localparam logic [ANGLE_BITS-1:0] SIGN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic [ANGLE_BITS-1:0] cur_key;
  logic [ANGLE_BITS-1:0] left_key;
  logic [ANGLE_BITS-1:0] right_key;
  logic [ANGLE_BITS-1:0] top_key;
  logic                  left_gt;
  logic                  right_gt;

  // Flipping the sign bit makes an unsigned compare order the signed keys.
  always_comb begin
    cur_key   = cur_angle ^ SIGN;
    left_key  = left_angle ^ SIGN;
    right_key = right_angle ^ SIGN;
    left_gt   = left_key > cur_key;
    top_key   = left_gt ? left_key : cur_key;
    right_gt  = has_right && (right_key > top_key);
    pick.take_right = right_gt;
    pick.take_left  = left_gt && !right_gt;
  end

endmodule

### rtl/heap_sort_points_by_angle.sv
// Collects point records (angle, x, y), one transfer per cycle while in the
// load state, into a single record memory; the transfer with tlast starts an
// in-place heap sort on the angle key, after which all stored records leave
// in ascending angle order, one record at a time, each held until the output
// side takes it. Every step of the sort uses the one memory read port: each
// heap level of a sift-down passes through states S_SL, S_SR and S_SD, and no
// input is taken while sorting or sending. Records beyond MAX_POINTS are
// dropped and the overflow flag in tuser is set on every result of that set.
// Equal angles come out in the order fixed by the heap-sort sequence.
`timescale 1ns / 1ps
`include "heap_sort_points_by_angle_defines.svh"

module heap_sort_points_by_angle
  import hspa_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // angle, x_coord, y_coord
  input  logic              s_tlast,   // last_item
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // sorted_angle, sorted_x, sorted_y
  output logic              m_tlast,   // last_result
  output logic              m_tuser    // overflowed
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = IDX_W + 2;
  localparam int REC_W = ANGLE_BITS + 2 * COORD_W;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_BUILD = 4'd1;
  localparam logic [3:0] S_BCUR  = 4'd2;
  localparam logic [3:0] S_SL    = 4'd3;
  localparam logic [3:0] S_SR    = 4'd4;
  localparam logic [3:0] S_SD    = 4'd5;
  localparam logic [3:0] S_SORT  = 4'd6;
  localparam logic [3:0] S_SR0   = 4'd7;
  localparam logic [3:0] S_SRL   = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OCAP  = 4'd10;
  localparam logic [3:0] S_OWAIT = 4'd11;

  logic [3:0]         state;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [CNT_W-1:0]   nrec;
  logic [CNT_W-1:0]   bidx;
  logic [CNT_W-1:0]   sidx;
  logic [CNT_W-1:0]   size;
  logic [IDX_W-1:0]   node;
  logic [IDX_W-1:0]   k;
  logic               in_build;
  logic               has_r;
  logic [REC_W-1:0]   cur;
  logic [REC_W-1:0]   lrec;

  logic [ANGLE_W-1:0] out_angle;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               out_last;
  logic               out_ovf;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [REC_W-1:0]   wdata;
  logic [IDX_W-1:0]   raddr;
  logic [REC_W-1:0]   rdata;

  logic [ANGLE_BITS+ANGLE_W-1:0] in_ext;
  logic [ANGLE_BITS+ANGLE_W-1:0] out_ext;
  logic [REC_W-1:0]              in_rec;
  logic [CW-1:0]                 left_w;
  logic [CW-1:0]                 right_w;
  logic [CW-1:0]                 size_w;
  logic                          has_left;
  logic                          has_right;
  logic                          accept_in;
  logic                          room;
  logic [CNT_W-1:0]              n_new;
  logic [CNT_W-1:0]              k_cnt_next;
  logic [REC_W-1:0]              top_rec;
  logic [IDX_W-1:0]              top_idx;
  logic [3:0]                    after_sift;
  pick_t                         pick;

  hspa_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  hspa_pick #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_pick (
    .cur_angle   (cur[ANGLE_BITS-1:0]),
    .left_angle  (lrec[ANGLE_BITS-1:0]),
    .right_angle (rdata[ANGLE_BITS-1:0]),
    .has_right   (has_r),
    .pick        (pick)
  );

  assign s_tready  = (state == S_LOAD);
  assign accept_in = s_tvalid && s_tready;
  assign m_tdata   = {out_y, out_x, out_angle};
  assign m_tlast   = out_last;
  assign m_tuser   = out_ovf;

  always_comb begin
    in_ext     = {{ANGLE_BITS{1'b0}}, s_tdata[ANGLE_W-1:0]};
    in_rec     = {s_tdata[DATA_W-1:ANGLE_W], in_ext[ANGLE_BITS-1:0]};
    out_ext    = {{ANGLE_W{1'b0}}, rdata[ANGLE_BITS-1:0]};
    room       = count < CNT_W'(MAX_POINTS);
    n_new      = room ? count + CNT_W'(1) : count;
    left_w     = {1'b0, node, 1'b1};
    right_w    = left_w + CW'(1);
    size_w     = CW'(size);
    has_left   = left_w < size_w;
    has_right  = right_w < size_w;
    k_cnt_next = CNT_W'(k) + CNT_W'(1);
    top_rec    = pick.take_right ? rdata : lrec;
    top_idx    = pick.take_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
    after_sift = in_build ? S_BUILD : S_SORT;
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = cur;
    raddr = node;
    unique case (state)
      S_LOAD: begin
        we    = accept_in && room;
        waddr = count[IDX_W-1:0];
        wdata = in_rec;
      end
      S_BUILD: begin
        raddr = IDX_W'(bidx - CNT_W'(1));
      end
      S_SL: begin
        raddr = left_w[IDX_W-1:0];
        we    = !has_left;
      end
      S_SR: begin
        raddr = right_w[IDX_W-1:0];
      end
      S_SD: begin
        we    = 1'b1;
        wdata = (pick.take_left || pick.take_right) ? top_rec : cur;
      end
      S_SORT: begin
        raddr = '0;
      end
      S_SR0: begin
        raddr = IDX_W'(sidx - CNT_W'(1));
      end
      S_SRL: begin
        we    = 1'b1;
        waddr = IDX_W'(sidx - CNT_W'(1));
        wdata = lrec;
      end
      S_ORD: begin
        raddr = k;
      end
      S_OWAIT: begin
        raddr = k + IDX_W'(1);
      end
      default: begin
        raddr = node;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
      in_build <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept_in) begin
            count <= n_new;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              nrec     <= n_new;
              bidx     <= n_new >> 1;
              in_build <= 1'b1;
              state    <= S_BUILD;
            end
          end
        end
        S_BUILD: begin
          if (bidx == '0) begin
            in_build <= 1'b0;
            sidx     <= nrec;
            state    <= S_SORT;
          end else begin
            node  <= IDX_W'(bidx - CNT_W'(1));
            size  <= nrec;
            bidx  <= bidx - CNT_W'(1);
            state <= S_BCUR;
          end
        end
        S_BCUR: begin
          cur   <= rdata;
          state <= S_SL;
        end
        S_SL: begin
          state <= has_left ? S_SR : after_sift;
        end
        S_SR: begin
          lrec  <= rdata;
          has_r <= has_right;
          state <= S_SD;
        end
        S_SD: begin
          if (pick.take_left || pick.take_right) begin
            node  <= top_idx;
            state <= S_SL;
          end else begin
            state <= after_sift;
          end
        end
        S_SORT: begin
          if (sidx <= CNT_W'(1)) begin
            k     <= '0;
            state <= S_ORD;
          end else begin
            state <= S_SR0;
          end
        end
        S_SR0: begin
          lrec  <= rdata;
          state <= S_SRL;
        end
        S_SRL: begin
          cur   <= rdata;
          node  <= '0;
          size  <= sidx - CNT_W'(1);
          sidx  <= sidx - CNT_W'(1);
          state <= S_SL;
        end
        S_ORD: begin
          state <= S_OCAP;
        end
        S_OCAP: begin
          out_angle <= out_ext[ANGLE_W-1:0];
          out_x     <= rdata[ANGLE_BITS +: COORD_W];
          out_y     <= rdata[ANGLE_BITS+COORD_W +: COORD_W];
          out_last  <= (k_cnt_next == nrec);
          out_ovf   <= ovf;
          m_tvalid  <= 1'b1;
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (out_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_OCAP;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `HSPA_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(MAX_POINTS), "record count above capacity")
  `HSPA_ASSERT_NOW(a_node_in_heap, state == S_SL, CW'(node) < size_w, "sift node outside the heap")
  `HSPA_ASSERT_NOW(a_out_index, m_tvalid, CNT_W'(k) < nrec, "result index beyond stored records")
  `HSPA_ASSERT_NEXT(a_set_cleared, m_tvalid && m_tready && m_tlast, (count == '0) && !ovf && s_tready, "set state not cleared after final result")

endmodule
